>>> rtl/core/lhist_pkg.sv
// ----------------------------------------------------------------------------
// lhist_pkg
// Shared types and constants of the log2 latency histogram unit.
// ----------------------------------------------------------------------------
package lhist_pkg;

  // Event kinds
  localparam logic [1:0] OP_ENTRY  = 2'd0;
  localparam logic [1:0] OP_RETURN = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_FILTERED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NO_START = 3'd3;
  localparam logic [2:0] ST_BAD_OP   = 3'd4;
  localparam logic [2:0] ST_NEGATIVE = 3'd5;
  localparam logic [2:0] ST_COUNTED  = 3'd6;
  localparam logic [2:0] ST_READ     = 3'd7;

  // Configuration register indexes
  localparam logic REG_FILTER = 1'b0;
  localparam logic REG_UNITS  = 1'b1;

  // Unit divisors (nanoseconds to micro / milliseconds)
  localparam int unsigned DIV_W = 20;
  localparam logic [DIV_W-1:0] US_DIVISOR = 20'd1000;
  localparam logic [DIV_W-1:0] MS_DIVISOR = 20'd1000000;

  // Rounded-up reciprocals: floor(x / d) == (x * RECIP) >> SHIFT for any
  // 63-bit x, with SHIFT = 63 + ceil(log2(d))
  localparam int unsigned US_SHIFT = 73;
  localparam int unsigned MS_SHIFT = 83;
  localparam logic [63:0] US_RECIP =
    64'(((128'd1 << US_SHIFT) + 128'(US_DIVISOR) - 128'd1) / 128'(US_DIVISOR));
  localparam logic [63:0] MS_RECIP =
    64'(((128'd1 << MS_SHIFT) + 128'(MS_DIVISOR) - 128'd1) / 128'(MS_DIVISOR));

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] thread_id;
    logic [31:0] process_id;
    logic [63:0] timestamp;
    logic [2:0]  operation_index;
    logic [4:0]  bucket_select;
  } evt_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  bucket;
    logic [31:0] bin_count;
    logic [62:0] scaled_latency;
  } res_item_t;

  // One word of the start table
  typedef struct packed {
    logic        valid;
    logic [31:0] thread;
    logic [63:0] stamp;
  } tbl_word_t;

  // Status of the start table towards the controller
  typedef struct packed {
    logic busy;   // clearing pass after reset
    logic done;   // scan finished (one cycle)
    logic match;  // thread found
    logic free;   // a free slot exists
  } tbl_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DELTA,
    S_DIV,
    S_HREAD,
    S_HUPD,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/latency_log2_histogram_unit.sv
// ----------------------------------------------------------------------------
// latency_log2_histogram_unit
// Operation latency profiler with per-operation floor-log2 histograms.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Entry and return events scan the whole
// start table, one slot a cycle; a return that finds its start and has a
// valid operation index then forms the delta, and unless it is negative
// goes on to the unit division by reciprocal multiplication and the bin
// read-modify-write. A read event reads its bin, or goes straight to its
// result when the operation index or the bin is out of range; a filtered
// entry also skips the scan. After reset the start table and the bins are
// cleared slot by slot; no event is taken until then. A finished result
// sits in an output register, so the next event can be accepted while it
// waits.
module latency_log2_histogram_unit #(
  parameter int unsigned TABLE_ENTRIES  = 1024,
  parameter int unsigned NUM_BUCKETS    = 32,
  parameter int unsigned NUM_OPERATIONS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  evt_valid,
  output logic                  evt_ready,
  input  lhist_pkg::evt_item_t  evt,
  output logic                  res_valid,
  input  logic                  res_ready,
  output lhist_pkg::res_item_t  res,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int unsigned IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned HDEP  = NUM_OPERATIONS * NUM_BUCKETS;
  localparam int unsigned HAW   = (HDEP > 1) ? $clog2(HDEP) : 1;
  localparam int unsigned BKW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  lhist_pkg::state_t    state, state_next;
  lhist_pkg::evt_item_t item;
  lhist_pkg::res_item_t res_q;

  logic [31:0]    filter;
  logic           millis;
  logic [63:0]    delta;
  logic [BKW-1:0] bkt;
  logic [HAW-1:0] haddr;

  // Table, divider and bin signals
  lhist_pkg::tbl_stat_t tstat;
  lhist_pkg::tbl_word_t tbl_wr_word;
  logic [IW-1:0]  match_slot, free_slot;
  logic [63:0]    match_time;
  logic           scan_start, tbl_wr_en;
  logic           div_start, div_done;
  logic [62:0]    quotient;
  logic [5:0]     lg;
  logic           bins_busy, bins_rd_en, bins_wr_en;
  logic [31:0]    bins_rd_data;

  logic           accept, filtered, evt_bad_op, evt_bsel_out, op_bad;
  logic [BKW-1:0] bkt_sat;

  assign accept       = evt_valid && evt_ready;
  assign filtered     = (filter != 32'd0) && (filter != evt.process_id);
  assign evt_bad_op   = evt.operation_index >= 3'(NUM_OPERATIONS);
  assign evt_bsel_out = {2'b00, evt.bucket_select} >= 7'(NUM_BUCKETS);
  assign op_bad       = item.operation_index >= 3'(NUM_OPERATIONS);
  assign bkt_sat      = (lg > 6'(NUM_BUCKETS - 1)) ? BKW'(NUM_BUCKETS - 1) : BKW'(lg);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter <= '0;
      millis <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lhist_pkg::REG_FILTER: filter <= cfg_data;
        lhist_pkg::REG_UNITS:  millis <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lhist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lhist_pkg::S_IDLE: begin
        if (accept) begin
          unique case (evt.op)
            lhist_pkg::OP_ENTRY:  state_next = filtered ? lhist_pkg::S_DONE : lhist_pkg::S_SCAN;
            lhist_pkg::OP_RETURN: state_next = lhist_pkg::S_SCAN;
            lhist_pkg::OP_READ:
              state_next = (evt_bad_op || evt_bsel_out) ? lhist_pkg::S_DONE
                                                        : lhist_pkg::S_HREAD;
            default: state_next = lhist_pkg::S_IDLE;
          endcase
        end
      end
      lhist_pkg::S_SCAN: begin
        if (tstat.done) begin
          if (item.op == lhist_pkg::OP_RETURN && tstat.match && !op_bad) begin
            state_next = lhist_pkg::S_DELTA;
          end else begin
            state_next = lhist_pkg::S_DONE;
          end
        end
      end
      lhist_pkg::S_DELTA: state_next = delta[63] ? lhist_pkg::S_DONE : lhist_pkg::S_DIV;
      lhist_pkg::S_DIV:   if (div_done) state_next = lhist_pkg::S_HREAD;
      lhist_pkg::S_HREAD: state_next = lhist_pkg::S_HUPD;
      lhist_pkg::S_HUPD:  state_next = lhist_pkg::S_DONE;
      lhist_pkg::S_DONE:  if (!res_valid || res_ready) state_next = lhist_pkg::S_IDLE;
      default:            state_next = lhist_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    evt_ready  = (state == lhist_pkg::S_IDLE) && !tstat.busy && !bins_busy;
    scan_start = (state == lhist_pkg::S_IDLE) && evt_valid && !tstat.busy && !bins_busy &&
                 ((evt.op == lhist_pkg::OP_ENTRY && !filtered) ||
                  evt.op == lhist_pkg::OP_RETURN);
    tbl_wr_en  = (state == lhist_pkg::S_SCAN) && tstat.done &&
                 ((item.op == lhist_pkg::OP_ENTRY) ? (tstat.match || tstat.free)
                                                   : tstat.match);
    div_start  = (state == lhist_pkg::S_DELTA) && !delta[63];
    bins_rd_en = (state == lhist_pkg::S_HREAD);
    bins_wr_en = (state == lhist_pkg::S_HUPD) && (item.op == lhist_pkg::OP_RETURN);
  end

  assign tbl_wr_word.valid  = (item.op == lhist_pkg::OP_ENTRY);
  assign tbl_wr_word.thread = item.thread_id;
  assign tbl_wr_word.stamp  = item.timestamp;

  // Item datapath and pending result
  always_ff @(posedge clk) begin
    unique case (state)
      lhist_pkg::S_IDLE: begin
        if (accept) begin
          item  <= evt;
          bkt   <= BKW'(evt.bucket_select);
          haddr <= HAW'(int'(evt.operation_index) * NUM_BUCKETS + int'(evt.bucket_select));
          if (evt.op == lhist_pkg::OP_ENTRY) begin
            res_q <= '{lhist_pkg::ST_FILTERED, 5'd0, 32'd0, 63'd0};
          end else if (evt_bad_op) begin
            res_q <= '{lhist_pkg::ST_BAD_OP, evt.bucket_select, 32'd0, 63'd0};
          end else begin
            res_q <= '{lhist_pkg::ST_READ, evt.bucket_select, 32'd0, 63'd0};
          end
        end
      end
      lhist_pkg::S_SCAN: begin
        if (tstat.done) begin
          delta <= item.timestamp - match_time;
          if (item.op == lhist_pkg::OP_ENTRY) begin
            res_q.status <= (tstat.match || tstat.free) ? lhist_pkg::ST_STORED
                                                        : lhist_pkg::ST_FULL;
          end else if (!tstat.match) begin
            res_q.status <= lhist_pkg::ST_NO_START;
          end else if (op_bad) begin
            res_q.status <= lhist_pkg::ST_BAD_OP;
          end else begin
            res_q.status <= lhist_pkg::ST_NEGATIVE;
          end
          res_q.bucket         <= 5'd0;
          res_q.bin_count      <= 32'd0;
          res_q.scaled_latency <= 63'd0;
        end
      end
      lhist_pkg::S_DIV: begin
        if (div_done) begin
          bkt   <= bkt_sat;
          haddr <= HAW'(int'(item.operation_index) * NUM_BUCKETS + int'(bkt_sat));
        end
      end
      lhist_pkg::S_HUPD: begin
        if (item.op == lhist_pkg::OP_RETURN) begin
          res_q <= '{lhist_pkg::ST_COUNTED, 5'(bkt), bins_rd_data + 32'd1, quotient};
        end else begin
          res_q.bin_count <= bins_rd_data;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == lhist_pkg::S_DONE && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lhist_pkg::S_DONE && (!res_valid || res_ready)) begin
      res <= res_q;
    end
  end

  lhist_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .scan_start (scan_start),
    .key        (item.thread_id),
    .stat       (tstat),
    .match_slot (match_slot),
    .free_slot  (free_slot),
    .match_time (match_time),
    .wr_en      (tbl_wr_en),
    .wr_slot    (tstat.match ? match_slot : free_slot),
    .wr_word    (tbl_wr_word)
  );

  lhist_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delta[62:0]),
    .millis   (millis),
    .done     (div_done),
    .quotient (quotient),
    .log2     (lg)
  );

  lhist_bins #(
    .DEPTH (HDEP)
  ) u_bins (
    .clk     (clk),
    .rst     (rst),
    .busy    (bins_busy),
    .rd_en   (bins_rd_en),
    .rd_addr (haddr),
    .rd_data (bins_rd_data),
    .wr_en   (bins_wr_en),
    .wr_addr (haddr),
    .wr_data (bins_rd_data + 32'd1)
  );

endmodule

>>> rtl/core/lhist_table.sv
// ----------------------------------------------------------------------------
// lhist_table
// Start table: one memory holding valid mark, thread id and start time per
// slot. A scan walks all slots, one read a cycle, and reports the first slot
// holding the key and the lowest free slot. Cleared slot by slot after reset.
// ----------------------------------------------------------------------------
module lhist_table #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     scan_start,
  input  logic [31:0]                              key,
  output lhist_pkg::tbl_stat_t                     stat,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] match_slot,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_slot,
  output logic [63:0]                              match_time,
  input  logic                                     wr_en,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_slot,
  input  lhist_pkg::tbl_word_t                     wr_word
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  lhist_pkg::tbl_word_t mem [ENTRIES];
  lhist_pkg::tbl_word_t rd_data;

  logic          clr_busy;
  logic [IW-1:0] clr_cnt;
  logic          scanning;
  logic [CW-1:0] iss;
  logic          iss_end;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;
  logic          done;
  logic          match_found;
  logic          free_found;

  assign iss_end = (iss == CW'(ENTRIES));

  // Memory write port: clearing pass, then controller writes
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_slot] <= wr_word;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[iss[IW-1:0]];
  end

  // Clear pass and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy    <= 1'b1;
      clr_cnt     <= '0;
      scanning    <= 1'b0;
      iss         <= '0;
      rd_pend     <= 1'b0;
      done        <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == IW'(ENTRIES - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (scan_start) begin
        scanning    <= 1'b1;
        iss         <= '0;
        rd_pend     <= 1'b0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (scanning) begin
        rd_pend <= !iss_end;
        if (!iss_end) begin
          iss <= iss + 1'b1;
        end
        if (rd_pend) begin
          if (rd_data.valid && rd_data.thread == key && !match_found) begin
            match_found <= 1'b1;
          end
          if (!rd_data.valid && !free_found) begin
            free_found <= 1'b1;
          end
        end
        if (iss_end && !rd_pend) begin
          scanning <= 1'b0;
          done     <= 1'b1;
        end
      end
    end
  end

  // Slot and time capture
  always_ff @(posedge clk) begin
    if (scanning) begin
      rd_idx <= iss[IW-1:0];
      if (rd_pend && rd_data.valid && rd_data.thread == key && !match_found) begin
        match_slot <= rd_idx;
        match_time <= rd_data.stamp;
      end
      if (rd_pend && !rd_data.valid && !free_found) begin
        free_slot <= rd_idx;
      end
    end
  end

  assign stat.busy  = clr_busy;
  assign stat.done  = done;
  assign stat.match = match_found;
  assign stat.free  = free_found;

endmodule

>>> rtl/core/lhist_div.sv
// ----------------------------------------------------------------------------
// lhist_div
// Unit conversion by reciprocal multiplication. The 63 by 64 bit product is
// built from four 32 by 32 bit partial products, one a cycle, then shifted
// down; floor(log2) of the quotient comes from a leading-one search.
// ----------------------------------------------------------------------------
module lhist_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] dividend,
  input  logic        millis,
  output logic        done,
  output logic [62:0] quotient,
  output logic [5:0]  log2
);

  logic          busy;
  logic          fin;
  logic [2:0]    step;
  logic [62:0]   dvd;
  logic [63:0]   recip;
  logic          ms;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  logic [1:0]    prod_sh;
  logic [127:0]  prod_al;
  logic [127:0]  acc;
  logic [62:0]   q_full;
  logic [5:0]    q_lg;

  // Operands of the partial product for this step
  always_comb begin
    unique case (step[1:0])
      2'd0: begin mul_a = dvd[31:0];          mul_b = recip[31:0];  end
      2'd1: begin mul_a = dvd[31:0];          mul_b = recip[63:32]; end
      2'd2: begin mul_a = {1'b0, dvd[62:32]}; mul_b = recip[31:0];  end
      2'd3: begin mul_a = {1'b0, dvd[62:32]}; mul_b = recip[63:32]; end
    endcase
  end

  // Align the registered partial product
  always_comb begin
    unique case (prod_sh)
      2'd0:       prod_al = {64'd0, prod};
      2'd1, 2'd2: prod_al = {32'd0, prod, 32'd0};
      2'd3:       prod_al = {prod, 64'd0};
    endcase
  end

  assign q_full = ms ? 63'(acc >> lhist_pkg::MS_SHIFT) : 63'(acc >> lhist_pkg::US_SHIFT);

  // Leading one of the quotient; zero and one both give bucket zero
  always_comb begin
    q_lg = '0;
    for (int i = 1; i < 63; i++) begin
      if (q_full[i]) q_lg = 6'(i);
    end
  end

  // Sequencing: five multiply and accumulate steps, then the result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == 3'd4) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      recip <= millis ? lhist_pkg::MS_RECIP : lhist_pkg::US_RECIP;
      ms    <= millis;
      step  <= '0;
      acc   <= '0;
    end else if (busy) begin
      step    <= step + 3'd1;
      prod    <= 64'(mul_a) * 64'(mul_b);
      prod_sh <= step[1:0];
      if (step != 3'd0) begin
        acc <= acc + prod_al;
      end
    end else if (fin) begin
      quotient <= q_full;
      log2     <= q_lg;
    end
  end

endmodule

>>> rtl/core/lhist_bins.sv
// ----------------------------------------------------------------------------
// lhist_bins
// Histogram bin memory with registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
module lhist_bins #(
  parameter int unsigned DEPTH = 160
) (
  input  logic                                   clk,
  input  logic                                   rst,
  output logic                                   busy,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [31:0]                            rd_data,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [31:0]                            wr_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] clr_cnt;

  // Clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/lhist_chk.sv
// ----------------------------------------------------------------------------
// lhist_chk
// Port-level checks of the latency histogram unit, bound to the top level.
// ----------------------------------------------------------------------------
module lhist_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 evt_valid,
  input logic                 evt_ready,
  input lhist_pkg::evt_item_t evt,
  input logic                 res_valid,
  input logic                 res_ready,
  input lhist_pkg::res_item_t res,
  input logic                 cfg_we,
  input logic                 cfg_index,
  input logic [31:0]          cfg_data
);

  // No result straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A waiting result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Only counted items carry a latency
  a_lat_only_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != lhist_pkg::ST_COUNTED |-> res.scaled_latency == 63'd0)
    else $error("latency on an item that was not counted");

  // Table outcomes carry no bin
  a_table_no_bin: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == lhist_pkg::ST_STORED || res.status == lhist_pkg::ST_FILTERED ||
                  res.status == lhist_pkg::ST_FULL || res.status == lhist_pkg::ST_NO_START ||
                  res.status == lhist_pkg::ST_NEGATIVE)
    |-> res.bucket == 5'd0 && res.bin_count == 32'd0)
    else $error("bin fields set on a table outcome");

endmodule

bind latency_log2_histogram_unit lhist_chk u_chk (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the log2 latency histogram unit. Entry, return and
// read items go in through a valid/ready driver. A model of the start table
// and of the histograms predicts the result of each accepted item. A monitor
// checks every returned result, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned BUCKETS = 32;
  localparam int unsigned OPS     = 5;
  localparam int unsigned POOL    = 12;
  localparam int unsigned SETTLE  = 1200;    // covers one full table scan
  localparam int unsigned WD_MAX  = 20000;

  logic                 clk;
  logic                 rst;
  logic                 evt_valid;
  logic                 evt_ready;
  lhist_pkg::evt_item_t evt;
  logic                 res_valid;
  logic                 res_ready;
  lhist_pkg::res_item_t res;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [31:0]          cfg_data;

  latency_log2_histogram_unit DUT (
    .clk(clk), .rst(rst),
    .evt_valid(evt_valid), .evt_ready(evt_ready), .evt(evt),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: start table, histograms and registers
  logic        slot_busy [SLOTS];
  logic [31:0] slot_thread [SLOTS];
  logic [63:0] slot_stamp [SLOTS];
  logic [31:0] hist_bin [OPS*BUCKETS];
  logic [31:0] pid_filter;
  logic        units_ms;

  lhist_pkg::evt_item_t event_q[$];
  lhist_pkg::res_item_t result_q[$];
  int          errors;
  bit          quiet;       // no idling in the last part of the run
  bit          hold_req;
  logic        evt_taken;
  int          send_gap;
  int          recv_gap;
  int          hold_cnt;
  int          wd_cnt;

  // Generator view of the threads in use
  logic [31:0] pool_tid [POOL];
  logic [63:0] pool_ts [POOL];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic lhist_pkg::evt_item_t mk_evt(logic [1:0] op, logic [31:0] tid,
                                                  logic [31:0] pid, logic [63:0] ts,
                                                  logic [2:0] opi, logic [4:0] bsel);
    lhist_pkg::evt_item_t e;
    e.op = op;
    e.thread_id = tid;
    e.process_id = pid;
    e.timestamp = ts;
    e.operation_index = opi;
    e.bucket_select = bsel;
    return e;
  endfunction

  function automatic lhist_pkg::res_item_t mk_res(logic [2:0] st, logic [4:0] b,
                                                  logic [31:0] cnt, logic [62:0] lat);
    lhist_pkg::res_item_t r;
    r.status = st;
    r.bucket = b;
    r.bin_count = cnt;
    r.scaled_latency = lat;
    return r;
  endfunction

  // Update the table/histogram model for one item; 0 when no result follows
  function automatic bit profile_event(lhist_pkg::evt_item_t e,
                                       output lhist_pkg::res_item_t r);
    int          hit;
    int          spare;
    logic [63:0] delta;
    logic [63:0] lat;
    logic [63:0] v;
    int          b;
    int          idx;
    hit = -1;
    spare = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i] && slot_thread[i] == e.thread_id && hit < 0) hit = i;
      if (!slot_busy[i] && spare < 0) spare = i;
    end
    case (e.op)
      lhist_pkg::OP_ENTRY: begin
        if (pid_filter != 0 && pid_filter != e.process_id) begin
          r = mk_res(lhist_pkg::ST_FILTERED, 0, 0, 0);
        end else begin
          if (hit < 0) hit = spare;
          if (hit < 0) begin
            r = mk_res(lhist_pkg::ST_FULL, 0, 0, 0);
          end else begin
            slot_busy[hit] = 1'b1;
            slot_thread[hit] = e.thread_id;
            slot_stamp[hit] = e.timestamp;
            r = mk_res(lhist_pkg::ST_STORED, 0, 0, 0);
          end
        end
        return 1'b1;
      end
      lhist_pkg::OP_RETURN: begin
        if (hit < 0) begin
          r = mk_res(lhist_pkg::ST_NO_START, 0, 0, 0);
          return 1'b1;
        end
        slot_busy[hit] = 1'b0;
        if (e.operation_index >= OPS) begin
          r = mk_res(lhist_pkg::ST_BAD_OP, 0, 0, 0);
          return 1'b1;
        end
        delta = e.timestamp - slot_stamp[hit];
        if (delta[63]) begin
          r = mk_res(lhist_pkg::ST_NEGATIVE, 0, 0, 0);
          return 1'b1;
        end
        lat = units_ms ? delta / 64'd1000000 : delta / 64'd1000;
        b = 0;
        v = lat;
        while (v > 1) begin
          v = v >> 1;
          b++;
        end
        if (b >= BUCKETS) b = BUCKETS - 1;
        idx = e.operation_index * BUCKETS + b;
        hist_bin[idx] = hist_bin[idx] + 32'd1;
        r = mk_res(lhist_pkg::ST_COUNTED, b[4:0], hist_bin[idx], lat[62:0]);
        return 1'b1;
      end
      lhist_pkg::OP_READ: begin
        if (e.operation_index >= OPS)
          r = mk_res(lhist_pkg::ST_BAD_OP, e.bucket_select, 0, 0);
        else if (e.bucket_select >= BUCKETS)
          r = mk_res(lhist_pkg::ST_READ, e.bucket_select, 0, 0);
        else
          r = mk_res(lhist_pkg::ST_READ, e.bucket_select,
                     hist_bin[e.operation_index * BUCKETS + e.bucket_select], 0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Input acceptance and prediction
  always @(posedge clk) begin
    lhist_pkg::res_item_t r;
    evt_taken <= evt_valid && evt_ready;
    if (!rst && evt_valid && evt_ready) begin
      if (profile_event(evt, r)) result_q.push_back(r);
    end
  end

  // Result checking
  always @(posedge clk) begin
    lhist_pkg::res_item_t x;
    if (!rst && res_valid && res_ready) begin
      if (result_q.size() == 0) begin
        $error("result with none expected: %p", res);
        errors++;
      end else begin
        x = result_q.pop_front();
        if (res.status !== x.status) begin
          $error("status: expected %0d actual %0d", x.status, res.status);
          errors++;
        end
        if (res.bucket !== x.bucket) begin
          $error("bucket: expected %0d actual %0d", x.bucket, res.bucket);
          errors++;
        end
        if (res.bin_count !== x.bin_count) begin
          $error("bin_count: expected %0d actual %0d", x.bin_count, res.bin_count);
          errors++;
        end
        if (res.scaled_latency !== x.scaled_latency) begin
          $error("scaled_latency: expected %0d actual %0d",
                 x.scaled_latency, res.scaled_latency);
          errors++;
        end
      end
    end
  end

  // Event driver, fed from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
      send_gap <= 0;
    end else if (!evt_valid || evt_taken) begin
      if (send_gap > 0) begin
        evt_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        evt_valid <= 1'b0;
        send_gap <= $urandom_range(0, 17);
      end else if (event_q.size() > 0) begin
        evt <= event_q.pop_front();
        evt_valid <= 1'b1;
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // Result-side readiness: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      recv_gap <= 0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      res_ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      res_ready <= 1'b0;
      hold_cnt <= 4000;
      hold_req <= 1'b0;
    end else if (recv_gap > 0) begin
      res_ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      res_ready <= 1'b0;
      recv_gap <= $urandom_range(0, 17);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (evt_valid && evt_ready) || (res_valid && res_ready)) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WD_MAX) begin
      $display("latency_log2_histogram_unit: mismatch");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  task automatic drain();
    wait (event_q.size() == 0 && !evt_valid && result_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == lhist_pkg::REG_FILTER) pid_filter = val;
    else units_ms = val[0];
  endtask

  // One random item, mostly well-formed entry/return pairs over the pool
  task automatic gen_random();
    int          k;
    int          pick;
    int          sh;
    logic [31:0] pid;
    logic [63:0] ts;
    logic [2:0]  opi;
    k = $urandom_range(0, POOL - 1);
    pick = $urandom_range(0, 99);
    pid = ($urandom_range(0, 3) != 0 && pid_filter != 0) ? pid_filter : $urandom;
    opi = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(OPS, 7))
                                      : 3'($urandom_range(0, OPS - 1));
    if (pick < 42) begin
      ts = {$urandom, $urandom};
      if ($urandom_range(0, 1)) ts[63] = 1'b0;
      pool_ts[k] = ts;
      event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, pool_tid[k], pid, ts, opi,
                               5'($urandom)));
    end else if (pick < 84) begin
      sh = $urandom_range(0, 63);
      if ($urandom_range(0, 1)) sh = $urandom_range(10, 40);
      ts = pool_ts[k] + ({$urandom, $urandom} >> sh);
      event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, pool_tid[k], pid, ts, opi,
                               5'($urandom)));
    end else if (pick < 96) begin
      event_q.push_back(mk_evt(lhist_pkg::OP_READ, $urandom, $urandom,
                               {$urandom, $urandom}, opi, 5'($urandom)));
    end else if (pick < 98) begin
      event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, $urandom, $urandom,
                               {$urandom, $urandom}, opi, 5'($urandom)));
    end else begin
      event_q.push_back(mk_evt(lhist_pkg::OP_UNUSED, $urandom, $urandom,
                               {$urandom, $urandom}, opi, 5'($urandom)));
    end
  endtask

  task automatic new_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_tid[i] = $urandom;
      pool_ts[i] = {1'b0, 31'($urandom), $urandom};
    end
    pool_tid[0] = 32'h0;
    pool_tid[1] = 32'hFFFF_FFFF;
  endtask

  // Stimulus sequence
  initial begin
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    evt = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    pid_filter = '0;
    units_ms = 1'b0;
    for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
    for (int i = 0; i < OPS*BUCKETS; i++) hist_bin[i] = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: zero latency, saturation, missing start, bad op, negative
    // delta, overwrite of a held start, reads at the edges, unused kind
    write_reg(lhist_pkg::REG_FILTER, 32'h0);
    write_reg(lhist_pkg::REG_UNITS, 32'h0);
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'h0, 32'h0, 64'h0, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, 32'h0, 32'h0, 64'd999, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0,
                             3'd4, 5'd31));
    event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, 32'hFFFF_FFFF, 32'h0,
                             64'h7FFF_FFFF_FFFF_FFFF, 3'd4, 5'd31));
    event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, 32'h1234, 32'h0, 64'h10, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'h5, 32'h1, 64'd100, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, 32'h5, 32'h1, 64'd5000, 3'd7, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'h6, 32'h1, 64'd100, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, 32'h6, 32'h1, 64'd50, 3'd1, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'h7, 32'h1, 64'd10, 3'd2, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'h7, 32'h1, 64'd2000, 3'd2, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, 32'h7, 32'h1, 64'd10010, 3'd2, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_READ, 32'h0, 32'h0, 64'h0, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_READ, 32'h0, 32'h0, 64'h0, 3'd4, 5'd31));
    event_q.push_back(mk_evt(lhist_pkg::OP_READ, 32'h0, 32'h0, 64'h0, 3'd2, 5'd3));
    event_q.push_back(mk_evt(lhist_pkg::OP_READ, 32'h0, 32'h0, 64'h0, 3'd5, 5'd9));
    event_q.push_back(mk_evt(lhist_pkg::OP_UNUSED, 32'h0, 32'h0, 64'h0, 3'd0, 5'd0));
    drain();

    // Milliseconds and filtering
    write_reg(lhist_pkg::REG_UNITS, 32'h1);
    write_reg(lhist_pkg::REG_FILTER, 32'h55);
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'h9, 32'h56, 64'd0, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_ENTRY, 32'h9, 32'h55, 64'd0, 3'd0, 5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_RETURN, 32'h9, 32'h56, 64'd5_000_000, 3'd3,
                             5'd0));
    event_q.push_back(mk_evt(lhist_pkg::OP_READ, 32'h0, 32'h0, 64'h0, 3'd3, 5'd2));
    drain();

    // Random phases over several settings, extremes among them; the last
    // phase runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(lhist_pkg::REG_FILTER, 32'h0);
          write_reg(lhist_pkg::REG_UNITS, 32'h0);
        end
        1: begin
          write_reg(lhist_pkg::REG_FILTER, 32'hFFFF_FFFF);
          write_reg(lhist_pkg::REG_UNITS, 32'h1);
        end
        2: begin
          write_reg(lhist_pkg::REG_FILTER, $urandom);
          write_reg(lhist_pkg::REG_UNITS, 32'h0);
        end
        default: begin
          quiet = 1'b1;
          write_reg(lhist_pkg::REG_FILTER, 32'h0);
          write_reg(lhist_pkg::REG_UNITS, 32'h1);
        end
      endcase
      new_pool();
      for (int n = 0; n < 200; n++) begin
        gen_random();
        if (ph == 1 && n == 20) begin
          wait (event_q.size() < 3);
          hold_req = 1'b1;
        end
        wait (event_q.size() < 4);
      end
      // sender pauses until every result is back
      drain();
    end

    event_q.push_back(mk_evt(lhist_pkg::OP_READ, 32'h0, 32'h0, 64'h0, 3'd0, 5'd0));

    wait (event_q.size() == 0 && !evt_valid && result_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("latency_log2_histogram_unit: match");
    end else begin
      $display("latency_log2_histogram_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> latency_log2_histogram_unit.f
rtl/core/lhist_pkg.sv
rtl/core/lhist_table.sv
rtl/core/lhist_div.sv
rtl/core/lhist_bins.sv
rtl/core/latency_log2_histogram_unit.sv
rtl/core/lhist_chk.sv
tb/sv/testbench.sv
